/* rtl/ttsp_pkg.sv */
// ----------------------------------------------------------------------------
// ttsp_pkg
// Shared types and constants of the transposition table store/probe block.
// ----------------------------------------------------------------------------
package ttsp_pkg;

	localparam int INDEX_BITS  = 16;
	localparam int SLOT_COUNT  = 1 << INDEX_BITS;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 15;

	localparam logic [CFG_INDEX_W-1:0] CFG_SEARCH_AGE     = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MATE_THRESHOLD = 1'd1;

	localparam logic [7:0]  SEARCH_AGE_RST     = 8'd0;
	localparam logic [14:0] MATE_THRESHOLD_RST = 15'd30000;

	localparam logic       CMD_PROBE = 1'b0;
	localparam logic       CMD_STORE = 1'b1;

	localparam logic signed [17:0] SCORE_MAX = 18'sd32767;
	localparam logic signed [17:0] SCORE_MIN = -18'sd32768;

	typedef struct packed {
		logic        cmd;
		logic [63:0] key;
		logic [15:0] score;
		logic [15:0] store_move;
		logic [6:0]  search_depth;
		logic [1:0]  bound_kind;
		logic [6:0]  ply;
	} in_item_t;

	typedef struct packed {
		logic        key_match;
		logic [63:0] entry_key;
		logic [15:0] entry_score;
		logic [15:0] entry_move;
		logic [6:0]  entry_depth;
		logic [1:0]  entry_bound;
		logic        replaced;
	} out_item_t;

	typedef struct packed {
		logic        cmd;
		logic [63:0] key;
		logic [15:0] score;
		logic [15:0] store_move;
		logic [6:0]  search_depth;
		logic [1:0]  bound_kind;
	} queue_item_t;

	typedef struct packed {
		logic [63:0] key;
		logic [15:0] score;
		logic [15:0] move;
		logic [6:0]  depth;
		logic [1:0]  bound;
		logic [7:0]  age;
	} slot_entry_t;

	localparam int SLOT_W = $bits(slot_entry_t);

endpackage

/* rtl/ttsp_ram.sv */
// ----------------------------------------------------------------------------
// ttsp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ttsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/ttsp_front.sv */
// ----------------------------------------------------------------------------
// ttsp_front
// Request intake: accepts requests, applies mate score adjustment by ply and
// hands them to the queue.
// ----------------------------------------------------------------------------
module ttsp_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [14:0]           mate_threshold,
	input  logic                  clearing,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  ttsp_pkg::in_item_t    in_data,
	input  logic                  q_full,
	output logic                  q_push,
	output ttsp_pkg::queue_item_t q_item
);

	logic                  valid_s1;
	ttsp_pkg::queue_item_t item_s1;
	logic                  accept;
	logic signed [17:0]    s_w;
	logic signed [17:0]    thr_w;
	logic signed [17:0]    ply_w;
	logic signed [17:0]    adj_w;
	logic [15:0]           sat_w;

	assign q_push   = valid_s1 && !q_full;
	assign in_stall = clearing || (valid_s1 && q_full);
	assign accept   = in_valid && !in_stall;
	assign q_item   = item_s1;

	// mate scores move away from zero by ply, then saturate
	always_comb begin
		s_w   = 18'(signed'(in_data.score));
		thr_w = signed'({3'b000, mate_threshold});
		ply_w = signed'({11'b0, in_data.ply});
		if (s_w > thr_w) begin
			adj_w = s_w + ply_w;
		end else if (s_w < -thr_w) begin
			adj_w = s_w - ply_w;
		end else begin
			adj_w = s_w;
		end
		if (adj_w > ttsp_pkg::SCORE_MAX) begin
			sat_w = ttsp_pkg::SCORE_MAX[15:0];
		end else if (adj_w < ttsp_pkg::SCORE_MIN) begin
			sat_w = ttsp_pkg::SCORE_MIN[15:0];
		end else begin
			sat_w = adj_w[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.cmd          <= in_data.cmd;
			item_s1.key          <= in_data.key;
			item_s1.score        <= sat_w;
			item_s1.store_move   <= in_data.store_move;
			item_s1.search_depth <= in_data.search_depth;
			item_s1.bound_kind   <= in_data.bound_kind;
		end
	end

endmodule

/* rtl/ttsp_queue.sv */
// ----------------------------------------------------------------------------
// ttsp_queue
// Short request queue between intake and table access.
// ----------------------------------------------------------------------------
module ttsp_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ttsp_pkg::queue_item_t push_item,
	input  logic                  pop,
	output ttsp_pkg::queue_item_t head,
	output logic                  empty,
	output logic                  full
);

	ttsp_pkg::queue_item_t           slots_q [ttsp_pkg::QUEUE_DEPTH];
	logic [ttsp_pkg::QPTR_W-1:0]     wr_q;
	logic [ttsp_pkg::QPTR_W-1:0]     rd_q;
	logic [ttsp_pkg::QPTR_W:0]       cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (ttsp_pkg::QPTR_W + 1)'(ttsp_pkg::QUEUE_DEPTH));
	assign head  = slots_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= push_item;
		end
	end

endmodule

/* rtl/ttsp_back.sv */
// ----------------------------------------------------------------------------
// ttsp_back
// Table access: clearing pass after reset, then per request a read of the slot,
// written back when a store replaces it; result held in an output register.
// ----------------------------------------------------------------------------
module ttsp_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            search_age,
	input  ttsp_pkg::queue_item_t q_head,
	input  logic                  q_empty,
	output logic                  q_pop,
	output logic                  clearing,
	output logic                  out_valid,
	input  logic                  out_stall,
	output ttsp_pkg::out_item_t   out_data
);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EXEC  = 3'b100
	} back_state_t;

	back_state_t                   state_q;
	back_state_t                   state_d;
	logic [ttsp_pkg::INDEX_BITS-1:0] clr_q;
	ttsp_pkg::queue_item_t         cur_q;
	logic                          out_valid_q;
	ttsp_pkg::out_item_t           out_q;
	ttsp_pkg::slot_entry_t         rd_entry;
	ttsp_pkg::slot_entry_t         new_entry;
	logic [ttsp_pkg::SLOT_W-1:0]   rdata;
	logic                          we;
	logic [ttsp_pkg::INDEX_BITS-1:0] waddr;
	logic [ttsp_pkg::SLOT_W-1:0]   wdata;
	logic                          fire;
	logic                          take;
	logic                          out_free;
	ttsp_pkg::out_item_t           res;

	ttsp_ram #(
		.WIDTH(ttsp_pkg::SLOT_W),
		.DEPTH(ttsp_pkg::SLOT_COUNT)
	) u_slots (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (q_pop),
		.raddr(q_head.key[ttsp_pkg::INDEX_BITS-1:0]),
		.rdata(rdata)
	);

	assign clearing  = (state_q == ST_CLEAR);
	assign out_free  = !out_valid_q || !out_stall;
	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign fire      = (state_q == ST_EXEC) && out_free;
	assign rd_entry  = rdata;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// replacement rule: empty slot, deeper or equal, stale age, or same key
	always_comb begin
		take = (cur_q.cmd == ttsp_pkg::CMD_STORE) &&
		       (rd_entry.key == '0 ||
		        cur_q.search_depth >= rd_entry.depth ||
		        rd_entry.age != search_age ||
		        rd_entry.key == cur_q.key);
		new_entry.key   = cur_q.key;
		new_entry.score = cur_q.score;
		new_entry.move  = cur_q.store_move;
		new_entry.depth = cur_q.search_depth;
		new_entry.bound = cur_q.bound_kind;
		new_entry.age   = search_age;

		res.key_match = (cur_q.cmd == ttsp_pkg::CMD_PROBE) &&
		                rd_entry.key != '0 && rd_entry.key == cur_q.key;
		res.replaced  = take;
		if (take) begin
			res.entry_key   = new_entry.key;
			res.entry_score = new_entry.score;
			res.entry_move  = new_entry.move;
			res.entry_depth = new_entry.depth;
			res.entry_bound = new_entry.bound;
		end else begin
			res.entry_key   = rd_entry.key;
			res.entry_score = rd_entry.score;
			res.entry_move  = rd_entry.move;
			res.entry_depth = rd_entry.depth;
			res.entry_bound = rd_entry.bound;
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = cur_q.key[ttsp_pkg::INDEX_BITS-1:0];
		wdata = new_entry;
		if (state_q == ST_CLEAR) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else if (fire && take) begin
			we = 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (&clr_q) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (q_pop) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (fire) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
		end
		if (fire) begin
			out_q <= res;
		end
	end

endmodule

/* rtl/transposition_table_store_probe.sv */
// a request passes the intake register, the queue, the slot read and the output register
// the table access finishes each request's slot memory read and any write before it takes another
// the intake and queue keep taking requests while a result waits at the output, until the queue fills
// reset: asynchronous, active low; a clearing pass then zeroes all 2^16 slots,
// during which in_stall stays high; config writes still work
// ----------------------------------------------------------------------------
// transposition_table_store_probe
// Direct-mapped transposition table with depth/age replacement and mate score
// adjustment on store.
// ----------------------------------------------------------------------------
module transposition_table_store_probe (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [ttsp_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [ttsp_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  ttsp_pkg::in_item_t                   in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output ttsp_pkg::out_item_t                  out_data
);

	logic [7:0]            search_age_q;
	logic [14:0]           mate_threshold_q;
	logic                  clearing;
	logic                  q_push;
	logic                  q_pop;
	logic                  q_empty;
	logic                  q_full;
	ttsp_pkg::queue_item_t q_item;
	ttsp_pkg::queue_item_t q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_age_q     <= ttsp_pkg::SEARCH_AGE_RST;
			mate_threshold_q <= ttsp_pkg::MATE_THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ttsp_pkg::CFG_SEARCH_AGE: begin
					search_age_q <= cfg_wdata[7:0];
				end
				ttsp_pkg::CFG_MATE_THRESHOLD: begin
					mate_threshold_q <= cfg_wdata[14:0];
				end
				default: begin
				end
			endcase
		end
	end

	ttsp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.mate_threshold(mate_threshold_q),
		.clearing      (clearing),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_data       (in_data),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_item        (q_item)
	);

	ttsp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_item(q_item),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty),
		.full     (q_full)
	);

	ttsp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.search_age(search_age_q),
		.q_head    (q_head),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.clearing  (clearing),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

`ifndef SYNTH
	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> in_stall)
		else $error("request taken during clearing pass");

	a_clear_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !out_valid)
		else $error("result offered during clearing pass");

	a_match_not_replaced: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.key_match) |-> !out_data.replaced)
		else $error("probe result marked as replaced");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push)
		else $error("queue overflow");
`endif

endmodule

/* bench/tt_entry_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tt_entry_checker
// Watches the request, result and register ports of the transposition table.
// Keeps its own copy of the slots and registers and predicts the slot contents,
// key match and replace decision for each request. Each result is checked
// field by field against the oldest prediction. Failures are counted.
// ----------------------------------------------------------------------------
module tt_entry_checker
	import ttsp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  in_item_t               in_data,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  out_item_t              out_data,
	output int                     fail_count,
	output int                     pending
);

	slot_entry_t table_mem [int];
	out_item_t   expected_entries [$];
	logic [7:0]  age_reg = SEARCH_AGE_RST;
	logic [14:0] thr_reg = MATE_THRESHOLD_RST;

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	function automatic logic [15:0] push_mate(input logic [15:0] raw, input logic [6:0] ply);
		int s;
		int t;
		int p;
		s = $signed(raw);
		t = thr_reg;
		p = ply;
		if (s > t) begin
			s = s + p;
		end else if (s < -t) begin
			s = s - p;
		end
		if (s > 32767) begin
			s = 32767;
		end
		if (s < -32768) begin
			s = -32768;
		end
		return 16'(s);
	endfunction

	function automatic out_item_t predict_access(input in_item_t r);
		slot_entry_t e;
		out_item_t   o;
		int          idx;
		bit          take;
		idx = int'(r.key[INDEX_BITS-1:0]);
		if (table_mem.exists(idx)) begin
			e = table_mem[idx];
		end else begin
			e = '0;
		end
		o = '0;
		if (r.cmd == CMD_PROBE) begin
			o.key_match = (e.key != 64'd0) && (e.key == r.key);
		end else begin
			take = (e.key == 64'd0) || (r.search_depth >= e.depth) ||
				(e.age != age_reg) || (e.key == r.key);
			if (take) begin
				e.key   = r.key;
				e.score = push_mate(r.score, r.ply);
				e.move  = r.store_move;
				e.depth = r.search_depth;
				e.bound = r.bound_kind;
				e.age   = age_reg;
				table_mem[idx] = e;
				o.replaced = 1'b1;
			end
		end
		o.entry_key   = e.key;
		o.entry_score = e.score;
		o.entry_move  = e.move;
		o.entry_depth = e.depth;
		o.entry_bound = e.bound;
		return o;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (got !== want) begin
			$error("%s expected %h got %h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (!arst_n) begin
			age_reg = SEARCH_AGE_RST;
			thr_reg = MATE_THRESHOLD_RST;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SEARCH_AGE: begin
						age_reg = cfg_wdata[7:0];
					end
					CFG_MATE_THRESHOLD: begin
						thr_reg = cfg_wdata[14:0];
					end
					default: begin
					end
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_entries.size() == 0) begin
					$error("result with no request outstanding: %h", out_data);
					fail_count++;
				end else begin
					want = expected_entries.pop_front();
					check_field("key_match", want.key_match, out_data.key_match);
					check_field("entry_key", want.entry_key, out_data.entry_key);
					check_field("entry_score", want.entry_score, out_data.entry_score);
					check_field("entry_move", want.entry_move, out_data.entry_move);
					check_field("entry_depth", want.entry_depth, out_data.entry_depth);
					check_field("entry_bound", want.entry_bound, out_data.entry_bound);
					check_field("replaced", want.replaced, out_data.replaced);
				end
			end
			if (in_valid && !in_stall) begin
				expected_entries.push_back(predict_access(in_data));
			end
		end
		pending = expected_entries.size();
	end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the transposition table store/probe block. A
// directed set covers empty slots, replacement rules, mate score adjustment
// with saturation, zero keys and the unused bound code; random phases then
// hammer a small pool of colliding keys under changing registers and idling.
// ----------------------------------------------------------------------------
module tb_top;
	import ttsp_pkg::*;

	localparam int WATCHDOG_LIMIT = 250000;
	localparam int HOLD_CYCLES    = 400;
	localparam int CHUNK_ITEMS    = 110;

	localparam logic [1:0] BOUND_EXACT  = 2'd0;
	localparam logic [1:0] BOUND_UPPER  = 2'd1;
	localparam logic [1:0] BOUND_LOWER  = 2'd2;
	localparam logic [1:0] BOUND_UNUSED = 2'd3;

	localparam logic [63:0] KEY_A    = 64'hA5A5_0000_1111_1234;
	localparam logic [63:0] KEY_B    = 64'h0000_0000_0002_1234;
	localparam logic [63:0] KEY_HIGH = 64'h0000_0001_0000_0000;
	localparam logic [63:0] KEY_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] KEY_ONES_ALIAS = 64'h7FFF_FFFF_FFFF_FFFF;

	localparam logic [15:0] SLOT_POOL [4] = '{16'h1234, 16'h0000, 16'hFFFF, 16'h00A5};
	localparam logic [47:0] UPPER_POOL [4] = '{48'h0, 48'hFFFF_FFFF_FFFF,
		48'h5A5A_0F0F_C3C3, 48'h0000_0000_0001};

	localparam logic [7:0]  AGE_SET [4] = '{8'd0, 8'd255, 8'd7, 8'd8};
	localparam logic [14:0] THR_SET [4] = '{15'd0, 15'd32767, 15'd30000, 15'd32640};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	in_item_t               in_data = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	out_item_t              out_data;

	int fail_count;
	int pending;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int stuck_cycles = 0;
	logic [14:0] cur_threshold = MATE_THRESHOLD_RST;

	transposition_table_store_probe dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	tt_entry_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// result side: random stall, or a long hold-off when asked for
	always @(negedge clk) begin
		if (hold_requests != hold_served) begin
			hold_served = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	function automatic in_item_t make_req(input logic cmd, input logic [63:0] key,
		input int score, input logic [15:0] move, input logic [6:0] depth,
		input logic [1:0] bound, input logic [6:0] ply);
		in_item_t r;
		r.cmd          = cmd;
		r.key          = key;
		r.score        = 16'(score);
		r.store_move   = move;
		r.search_depth = depth;
		r.bound_kind   = bound;
		r.ply          = ply;
		return r;
	endfunction

	function automatic in_item_t random_request();
		logic [63:0] key;
		int          score;
		int          thr;
		logic [6:0]  depth;
		thr = cur_threshold;
		if ($urandom_range(9) < 2) begin
			key = {$urandom, $urandom};
		end else begin
			key = {UPPER_POOL[$urandom_range(3)], SLOT_POOL[$urandom_range(3)]};
		end
		case ($urandom_range(9))
			0, 1: begin
				score = thr + $urandom_range(2) - 1;
			end
			2, 3: begin
				score = -thr + $urandom_range(2) - 1;
			end
			4: begin
				score = $urandom_range(1) ? 32767 - $urandom_range(200) : -32768 + $urandom_range(200);
			end
			default: begin
				score = $urandom_range(64000) - 32000;
			end
		endcase
		depth = $urandom_range(1) ? 7'($urandom_range(127)) : 7'($urandom_range(7));
		return make_req($urandom_range(1) ? CMD_STORE : CMD_PROBE, key, score,
			16'($urandom), depth, 2'($urandom_range(3)), 7'($urandom_range(127)));
	endfunction

	task automatic send_request(input in_item_t r);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= r;
		do begin
			@(posedge clk);
		end while (in_stall);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic write_config(input logic [7:0] age, input logic [14:0] thr);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_SEARCH_AGE;
		cfg_wdata <= CFG_DATA_W'(age);
		@(negedge clk);
		cfg_index <= CFG_MATE_THRESHOLD;
		cfg_wdata <= thr;
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_threshold = thr;
	endtask

	initial begin
		int setting;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		write_config(8'd5, 15'd30000);

		// empty slots, then replacement rules on one slot
		send_request(make_req(CMD_PROBE, KEY_A, 0, 16'h0, 7'd0, BOUND_EXACT, 7'd0));
		send_request(make_req(CMD_PROBE, 64'd0, 0, 16'h0, 7'd0, BOUND_EXACT, 7'd0));
		send_request(make_req(CMD_STORE, KEY_A, 32000, 16'hFFFF, 7'd10, BOUND_EXACT, 7'd127));
		send_request(make_req(CMD_PROBE, KEY_A, 0, 16'h0, 7'd0, BOUND_EXACT, 7'd0));
		send_request(make_req(CMD_STORE, KEY_B, 100, 16'h1111, 7'd5, BOUND_UPPER, 7'd3));
		send_request(make_req(CMD_STORE, KEY_B, -32000, 16'h2222, 7'd10, BOUND_LOWER, 7'd127));
		send_request(make_req(CMD_STORE, KEY_A, 7, 16'h3333, 7'd0, BOUND_EXACT, 7'd1));
		// mate range edges and saturation on a key match
		send_request(make_req(CMD_STORE, KEY_B, 30000, 16'h4444, 7'd0, BOUND_EXACT, 7'd5));
		send_request(make_req(CMD_STORE, KEY_B, -30000, 16'h5555, 7'd127, BOUND_UNUSED, 7'd5));
		send_request(make_req(CMD_STORE, KEY_B, 30001, 16'h6666, 7'd3, BOUND_UPPER, 7'd127));
		send_request(make_req(CMD_STORE, KEY_B, -30001, 16'h6667, 7'd3, BOUND_UPPER, 7'd127));
		send_request(make_req(CMD_STORE, KEY_B, 32767, 16'h7777, 7'd3, BOUND_LOWER, 7'd127));
		send_request(make_req(CMD_STORE, KEY_B, -32768, 16'h8888, 7'd3, BOUND_LOWER, 7'd1));
		send_request(make_req(CMD_STORE, KEY_B, 32700, 16'h9999, 7'd3, BOUND_EXACT, 7'd127));
		send_request(make_req(CMD_PROBE, KEY_B, 0, 16'h0, 7'd0, BOUND_EXACT, 7'd0));
		// zero key stored leaves the slot looking empty
		send_request(make_req(CMD_STORE, 64'd0, 55, 16'hABCD, 7'd127, BOUND_EXACT, 7'd9));
		send_request(make_req(CMD_PROBE, 64'd0, 0, 16'h0, 7'd0, BOUND_EXACT, 7'd0));
		send_request(make_req(CMD_STORE, KEY_HIGH, -55, 16'h0001, 7'd0, BOUND_UPPER, 7'd9));
		send_request(make_req(CMD_PROBE, KEY_HIGH, 0, 16'h0, 7'd0, BOUND_EXACT, 7'd0));
		send_request(make_req(CMD_STORE, KEY_ONES, 0, 16'h0000, 7'd127, BOUND_UNUSED, 7'd127));
		send_request(make_req(CMD_PROBE, KEY_ONES, 0, 16'h0, 7'd0, BOUND_EXACT, 7'd0));
		send_request(make_req(CMD_PROBE, KEY_ONES_ALIAS, 0, 16'h0, 7'd0, BOUND_EXACT, 7'd0));

		setting = 0;
		for (int mode = 0; mode < 3; mode++) begin
			tx_idle_pct = (mode == 0) ? 7 : (mode == 1) ? 70 : 0;
			rx_idle_pct = (mode == 0) ? 70 : (mode == 1) ? 7 : 0;
			for (int chunk = 0; chunk < 3; chunk++) begin
				wait_drained();
				if (setting < 4) begin
					write_config(AGE_SET[setting], THR_SET[setting]);
				end else begin
					write_config(8'($urandom_range(255)), 15'($urandom_range(32767)));
				end
				setting++;
				if (mode == 2 && chunk == 1) begin
					hold_requests++;
				end
				repeat (CHUNK_ITEMS) send_request(random_request());
			end
		end

		wait_drained();
		repeat (20) @(negedge clk);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

/* transposition_table_store_probe.f */
rtl/ttsp_pkg.sv
rtl/ttsp_ram.sv
rtl/ttsp_front.sv
rtl/ttsp_queue.sv
rtl/ttsp_back.sv
rtl/transposition_table_store_probe.sv
bench/tt_entry_checker.sv
bench/tb_top.sv
